/* design/lkvc_pkg.sv */
`default_nettype none

package lkvc_pkg;

    // default sizes of the store
    localparam int MAX_ENTRIES_DEF = 16;
    localparam int KEY_BITS_DEF    = 32;
    localparam int VALUE_BITS_DEF  = 64;

    // capacity register
    localparam int          CAP_W     = 5;
    localparam logic [4:0]  CAP_RESET = 5'd16;

    // configuration port
    localparam int          APB_AW     = 3;
    localparam int          APB_DW     = 32;
    localparam logic        REG_CAPACITY = 1'b0;

    // request kinds
    localparam logic CMD_READ  = 1'b0;
    localparam logic CMD_WRITE = 1'b1;

endpackage

`default_nettype wire

/* design/lru_key_value_cache.sv */
`default_nettype none

// channel   | direction | handshake              | payload
// ----------+-----------+------------------------+----------------------------------------
// config    | in/out    | psel penable pwrite    | paddr pwdata prdata (pready always high)
// request   | in        | req_valid / req_ready  | cmd req_key write_data backing_data
//           |           |                        | external_dirty
// response  | out       | rsp_valid / rsp_ready  | read_data was_hit did_evict evicted_key
//           |           |                        | subscribe
//
// one request at a time: the key memory is scanned one entry per cycle on its read port,
// so a request passes the scan and then ST_INSERT on a miss, or ST_HIT_RD and ST_HIT_WR
// on a hit, from the accepting beat to the response register being loaded.
// reset clears valid bits, ranks and occupancy at once; key and value memories are not
// cleared. a response waiting on rsp_ready holds the block before its final write-back,
// while a new request is taken as soon as the previous one has reached the response register.

module lru_key_value_cache #(
    parameter int MAX_ENTRIES = lkvc_pkg::MAX_ENTRIES_DEF,
    parameter int KEY_BITS    = lkvc_pkg::KEY_BITS_DEF,
    parameter int VALUE_BITS  = lkvc_pkg::VALUE_BITS_DEF
) (
    input  wire logic                        clk,
    input  wire logic                        rst_n,

    input  wire logic                        psel,
    input  wire logic                        penable,
    input  wire logic                        pwrite,
    input  wire logic [lkvc_pkg::APB_AW-1:0] paddr,
    input  wire logic [lkvc_pkg::APB_DW-1:0] pwdata,
    output logic      [lkvc_pkg::APB_DW-1:0] prdata,
    output logic                             pready,

    input  wire logic                        req_valid,
    output logic                             req_ready,
    input  wire logic                        cmd,
    input  wire logic [KEY_BITS-1:0]         req_key,
    input  wire logic [VALUE_BITS-1:0]       write_data,
    input  wire logic [VALUE_BITS-1:0]       backing_data,
    input  wire logic                        external_dirty,

    output logic                             rsp_valid,
    input  wire logic                        rsp_ready,
    output logic      [VALUE_BITS-1:0]       read_data,
    output logic                             was_hit,
    output logic                             did_evict,
    output logic      [KEY_BITS-1:0]         evicted_key,
    output logic                             subscribe
);

    localparam int IDX_W = $clog2(MAX_ENTRIES);
    localparam int CNT_W = $clog2(MAX_ENTRIES + 1);
    localparam int CMP_W = (CNT_W > lkvc_pkg::CAP_W) ? CNT_W : lkvc_pkg::CAP_W;
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(MAX_ENTRIES - 1);

    typedef enum logic [4:0] {
        ST_IDLE   = 5'b00001,
        ST_SCAN   = 5'b00010,
        ST_HIT_RD = 5'b00100,
        ST_HIT_WR = 5'b01000,
        ST_INSERT = 5'b10000
    } state_t;

    state_t state_reg, state_next;

    // configuration
    logic [lkvc_pkg::CAP_W-1:0] cap_reg, cap_next;

    // entry status in flip-flops
    logic [MAX_ENTRIES-1:0] valid_reg, valid_next;
    logic [IDX_W-1:0]       rank_reg  [MAX_ENTRIES];
    logic [IDX_W-1:0]       rank_next [MAX_ENTRIES];
    logic [CNT_W-1:0]       occ_reg, occ_next;

    // scan control
    logic [IDX_W-1:0] rd_idx_reg, rd_idx_next;
    logic             issue_done_reg, issue_done_next;
    logic             chk_vld_reg, chk_vld_next;
    logic [IDX_W-1:0] chk_idx_reg, chk_idx_next;

    // scan results
    logic             hit_found_reg, hit_found_next;
    logic [IDX_W-1:0] hit_idx_reg, hit_idx_next;
    logic             vic_found_reg, vic_found_next;
    logic [IDX_W-1:0] vic_idx_reg, vic_idx_next;
    logic [IDX_W-1:0] vic_rank_reg, vic_rank_next;
    logic [KEY_BITS-1:0] vic_key_reg, vic_key_next;
    logic             free_found_reg, free_found_next;
    logic [IDX_W-1:0] free_idx_reg, free_idx_next;

    // captured request
    logic                  cmd_reg, cmd_next;
    logic [KEY_BITS-1:0]   key_reg, key_next;
    logic [VALUE_BITS-1:0] wdata_reg, wdata_next;
    logic [VALUE_BITS-1:0] bdata_reg, bdata_next;
    logic                  dirty_reg, dirty_next;

    // response register
    logic                  rsp_valid_reg, rsp_valid_next;
    logic [VALUE_BITS-1:0] rdata_reg, rdata_next;
    logic                  hit_reg, hit_next;
    logic                  evict_reg, evict_next;
    logic [KEY_BITS-1:0]   ekey_reg, ekey_next;
    logic                  sub_reg, sub_next;

    // memory ports
    logic                  key_we;
    logic [IDX_W-1:0]      key_waddr;
    logic [KEY_BITS-1:0]   key_rdata;
    logic                  val_we;
    logic [IDX_W-1:0]      val_waddr;
    logic [VALUE_BITS-1:0] val_wdata;
    logic [VALUE_BITS-1:0] val_rdata;

    logic             req_beat;
    logic             cfg_write;
    logic             out_free;
    logic [CMP_W-1:0] cap_eff;
    logic             need_evict;
    logic [IDX_W-1:0] ins_slot;
    logic             can_insert;
    logic             chk_entry_valid;
    logic [IDX_W-1:0] chk_rank;
    logic [IDX_W-1:0] hit_rank;

    lkvc_ram #(
        .WIDTH (KEY_BITS),
        .DEPTH (MAX_ENTRIES)
    ) u_key_ram (
        .clk   (clk),
        .we    (key_we),
        .waddr (key_waddr),
        .wdata (key_reg),
        .raddr (rd_idx_reg),
        .rdata (key_rdata)
    );

    lkvc_ram #(
        .WIDTH (VALUE_BITS),
        .DEPTH (MAX_ENTRIES)
    ) u_val_ram (
        .clk   (clk),
        .we    (val_we),
        .waddr (val_waddr),
        .wdata (val_wdata),
        .raddr (hit_idx_reg),
        .rdata (val_rdata)
    );

    // handshakes and port outputs
    assign pready      = 1'b1;
    assign cfg_write   = psel && penable && pwrite && (paddr[2] == lkvc_pkg::REG_CAPACITY);
    assign prdata      = (paddr[2] == lkvc_pkg::REG_CAPACITY)
                         ? {{(lkvc_pkg::APB_DW - lkvc_pkg::CAP_W){1'b0}}, cap_reg}
                         : '0;
    assign req_ready   = (state_reg == ST_IDLE);
    assign req_beat    = req_valid && req_ready;
    assign out_free    = !rsp_valid_reg || rsp_ready;
    assign rsp_valid   = rsp_valid_reg;
    assign read_data   = rdata_reg;
    assign was_hit     = hit_reg;
    assign did_evict   = evict_reg;
    assign evicted_key = ekey_reg;
    assign subscribe   = sub_reg;

    // effective capacity: zero acts as one, clamp to the store size
    always_comb
    begin
        if (cap_reg == '0)
        begin
            cap_eff = CMP_W'(1);
        end
        else if (CMP_W'(cap_reg) > CMP_W'(MAX_ENTRIES))
        begin
            cap_eff = CMP_W'(MAX_ENTRIES);
        end
        else
        begin
            cap_eff = CMP_W'(cap_reg);
        end
    end

    // insert slot selection
    assign need_evict = (CMP_W'(occ_reg) >= cap_eff) && (occ_reg != '0) && vic_found_reg;
    assign ins_slot   = need_evict ? vic_idx_reg : free_idx_reg;
    assign can_insert = need_evict || free_found_reg;

    // entry under compare in the scan
    assign chk_entry_valid = valid_reg[chk_idx_reg];
    assign chk_rank        = rank_reg[chk_idx_reg];
    assign hit_rank        = rank_reg[hit_idx_reg];

    // memory writes
    always_comb
    begin
        key_we    = 1'b0;
        key_waddr = ins_slot;
        val_we    = 1'b0;
        val_waddr = ins_slot;
        val_wdata = (cmd_reg == lkvc_pkg::CMD_WRITE) ? wdata_reg : bdata_reg;
        if (state_reg == ST_INSERT && out_free && can_insert)
        begin
            key_we = 1'b1;
            val_we = 1'b1;
        end
        else if (state_reg == ST_HIT_WR)
        begin
            val_waddr = hit_idx_reg;
            val_we    = out_free && ((cmd_reg == lkvc_pkg::CMD_WRITE) || dirty_reg);
        end
    end

    // control and next state
    always_comb
    begin
        state_next      = state_reg;
        cap_next        = cfg_write ? pwdata[lkvc_pkg::CAP_W-1:0] : cap_reg;
        valid_next      = valid_reg;
        rank_next       = rank_reg;
        occ_next        = occ_reg;
        rd_idx_next     = rd_idx_reg;
        issue_done_next = issue_done_reg;
        chk_vld_next    = 1'b0;
        chk_idx_next    = chk_idx_reg;
        hit_found_next  = hit_found_reg;
        hit_idx_next    = hit_idx_reg;
        vic_found_next  = vic_found_reg;
        vic_idx_next    = vic_idx_reg;
        vic_rank_next   = vic_rank_reg;
        vic_key_next    = vic_key_reg;
        free_found_next = free_found_reg;
        free_idx_next   = free_idx_reg;
        cmd_next        = cmd_reg;
        key_next        = key_reg;
        wdata_next      = wdata_reg;
        bdata_next      = bdata_reg;
        dirty_next      = dirty_reg;
        rsp_valid_next  = rsp_valid_reg && !rsp_ready;
        rdata_next      = rdata_reg;
        hit_next        = hit_reg;
        evict_next      = evict_reg;
        ekey_next       = ekey_reg;
        sub_next        = sub_reg;

        case (state_reg)
            ST_IDLE:
            begin
                if (req_beat)
                begin
                    cmd_next        = cmd;
                    key_next        = req_key;
                    wdata_next      = write_data;
                    bdata_next      = backing_data;
                    dirty_next      = external_dirty;
                    rd_idx_next     = '0;
                    issue_done_next = 1'b0;
                    hit_found_next  = 1'b0;
                    vic_found_next  = 1'b0;
                    free_found_next = 1'b0;
                    state_next      = ST_SCAN;
                end
            end

            ST_SCAN:
            begin
                // issue one key read per cycle
                if (!issue_done_reg)
                begin
                    chk_vld_next = 1'b1;
                    chk_idx_next = rd_idx_reg;
                    if (rd_idx_reg == LAST_IDX)
                    begin
                        issue_done_next = 1'b1;
                    end
                    else
                    begin
                        rd_idx_next = rd_idx_reg + 1'b1;
                    end
                end
                // compare the entry read last cycle
                if (chk_vld_reg)
                begin
                    if (chk_entry_valid && key_rdata == key_reg && !hit_found_reg)
                    begin
                        hit_found_next = 1'b1;
                        hit_idx_next   = chk_idx_reg;
                    end
                    if (chk_entry_valid && (!vic_found_reg || chk_rank > vic_rank_reg))
                    begin
                        vic_found_next = 1'b1;
                        vic_idx_next   = chk_idx_reg;
                        vic_rank_next  = chk_rank;
                        vic_key_next   = key_rdata;
                    end
                    if (!chk_entry_valid && !free_found_reg)
                    begin
                        free_found_next = 1'b1;
                        free_idx_next   = chk_idx_reg;
                    end
                    if (chk_idx_reg == LAST_IDX)
                    begin
                        state_next = hit_found_next ? ST_HIT_RD : ST_INSERT;
                    end
                end
            end

            ST_HIT_RD:
            begin
                // value memory read of the hit entry is in flight
                state_next = ST_HIT_WR;
            end

            ST_HIT_WR:
            begin
                if (out_free)
                begin
                    // make the hit entry most recent
                    for (int i = 0; i < MAX_ENTRIES; i++)
                    begin
                        if (valid_reg[i] && IDX_W'(i) != hit_idx_reg && rank_reg[i] < hit_rank)
                        begin
                            rank_next[i] = rank_reg[i] + 1'b1;
                        end
                    end
                    rank_next[hit_idx_reg] = '0;
                    rsp_valid_next = 1'b1;
                    hit_next       = 1'b1;
                    evict_next     = 1'b0;
                    ekey_next      = '0;
                    sub_next       = 1'b0;
                    if (cmd_reg == lkvc_pkg::CMD_WRITE)
                    begin
                        rdata_next = '0;
                    end
                    else if (dirty_reg)
                    begin
                        rdata_next = bdata_reg;
                    end
                    else
                    begin
                        rdata_next = val_rdata;
                    end
                    state_next = ST_IDLE;
                end
            end

            ST_INSERT:
            begin
                if (out_free)
                begin
                    if (can_insert)
                    begin
                        // all surviving entries age by one
                        for (int i = 0; i < MAX_ENTRIES; i++)
                        begin
                            if (valid_reg[i] && !(need_evict && IDX_W'(i) == vic_idx_reg))
                            begin
                                rank_next[i] = rank_reg[i] + 1'b1;
                            end
                        end
                        rank_next[ins_slot]  = '0;
                        valid_next[ins_slot] = 1'b1;
                        if (!need_evict)
                        begin
                            occ_next = occ_reg + 1'b1;
                        end
                    end
                    rsp_valid_next = 1'b1;
                    hit_next       = 1'b0;
                    evict_next     = need_evict;
                    ekey_next      = need_evict ? vic_key_reg : '0;
                    sub_next       = (cmd_reg == lkvc_pkg::CMD_READ);
                    rdata_next     = (cmd_reg == lkvc_pkg::CMD_READ) ? bdata_reg : '0;
                    state_next     = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            cap_reg        <= lkvc_pkg::CAP_RESET;
            valid_reg      <= '0;
            for (int i = 0; i < MAX_ENTRIES; i++)
            begin
                rank_reg[i] <= '0;
            end
            occ_reg        <= '0;
            rd_idx_reg     <= '0;
            issue_done_reg <= 1'b0;
            chk_vld_reg    <= 1'b0;
            hit_found_reg  <= 1'b0;
            vic_found_reg  <= 1'b0;
            free_found_reg <= 1'b0;
            rsp_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            cap_reg        <= cap_next;
            valid_reg      <= valid_next;
            rank_reg       <= rank_next;
            occ_reg        <= occ_next;
            rd_idx_reg     <= rd_idx_next;
            issue_done_reg <= issue_done_next;
            chk_vld_reg    <= chk_vld_next;
            hit_found_reg  <= hit_found_next;
            vic_found_reg  <= vic_found_next;
            free_found_reg <= free_found_next;
            rsp_valid_reg  <= rsp_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        chk_idx_reg  <= chk_idx_next;
        hit_idx_reg  <= hit_idx_next;
        vic_idx_reg  <= vic_idx_next;
        vic_rank_reg <= vic_rank_next;
        vic_key_reg  <= vic_key_next;
        free_idx_reg <= free_idx_next;
        cmd_reg      <= cmd_next;
        key_reg      <= key_next;
        wdata_reg    <= wdata_next;
        bdata_reg    <= bdata_next;
        dirty_reg    <= dirty_next;
        rdata_reg    <= rdata_next;
        hit_reg      <= hit_next;
        evict_reg    <= evict_next;
        ekey_reg     <= ekey_next;
        sub_reg      <= sub_next;
    end

endmodule

`default_nettype wire

/* design/lkvc_ram.sv */
`default_nettype none

module lkvc_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

/* sim/tb_lru_key_value_cache.sv */
`timescale 1ns / 100ps

module tb_lru_key_value_cache;

    localparam int ENTRIES      = lkvc_pkg::MAX_ENTRIES_DEF;
    localparam int KEY_W        = lkvc_pkg::KEY_BITS_DEF;
    localparam int VAL_W        = lkvc_pkg::VALUE_BITS_DEF;
    localparam int ADDR_W       = lkvc_pkg::APB_AW;
    localparam int DATA_W       = lkvc_pkg::APB_DW;
    localparam int CAP_BITS     = lkvc_pkg::CAP_W;
    localparam int SETTLE       = 2 * (ENTRIES + 4);
    localparam int CYCLE_LIMIT  = 500000;
    localparam int HOLD_AT      = 500;
    localparam int HOLD_CYCLES  = 300;
    localparam int POOL_SIZE    = 24;
    localparam int PHASE_ITEMS  = 170;
    localparam logic [ADDR_W-1:0] CAP_ADDR = ADDR_W'(4 * int'(lkvc_pkg::REG_CAPACITY));

    typedef struct packed {
        logic             cmd;
        logic [KEY_W-1:0] key;
        logic [VAL_W-1:0] wdata;
        logic [VAL_W-1:0] bdata;
        logic             dirty;
    } cache_req_t;

    typedef struct packed {
        logic [VAL_W-1:0] data;
        logic             hit;
        logic             evict;
        logic [KEY_W-1:0] ekey;
        logic             sub;
    } cache_rsp_t;

    // clock and reset
    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    // configuration port
    logic              psel    = 1'b0;
    logic              penable = 1'b0;
    logic              pwrite  = 1'b0;
    logic [ADDR_W-1:0] paddr   = '0;
    logic [DATA_W-1:0] pwdata  = '0;
    logic [DATA_W-1:0] prdata;
    logic              pready;

    // request channel
    logic             req_valid      = 1'b0;
    logic             req_ready;
    logic             cmd            = lkvc_pkg::CMD_READ;
    logic [KEY_W-1:0] req_key        = '0;
    logic [VAL_W-1:0] write_data     = '0;
    logic [VAL_W-1:0] backing_data   = '0;
    logic             external_dirty = 1'b0;

    // response channel
    logic             rsp_valid;
    logic             rsp_ready = 1'b0;
    logic [VAL_W-1:0] read_data;
    logic             was_hit;
    logic             did_evict;
    logic [KEY_W-1:0] evicted_key;
    logic             subscribe;

    // shadow copy of the store
    logic [KEY_W-1:0] shadow_key [ENTRIES];
    logic [VAL_W-1:0] shadow_val [ENTRIES];
    bit               shadow_live[ENTRIES];
    int unsigned      shadow_age [ENTRIES];
    int unsigned      live_count   = 0;
    logic [CAP_BITS-1:0] capacity_reg = lkvc_pkg::CAP_RESET;

    cache_req_t       pending_reqs[$];
    cache_rsp_t       expected_rsps[$];
    logic [KEY_W-1:0] key_pool[POOL_SIZE];

    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int fail_count    = 0;
    int cycle_count   = 0;
    int rsp_seen      = 0;
    int hold_left     = 0;
    bit hold_done     = 1'b0;

    lru_key_value_cache u_top (
        .clk            (clk),
        .rst_n          (rst_n),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready),
        .req_valid      (req_valid),
        .req_ready      (req_ready),
        .cmd            (cmd),
        .req_key        (req_key),
        .write_data     (write_data),
        .backing_data   (backing_data),
        .external_dirty (external_dirty),
        .rsp_valid      (rsp_valid),
        .rsp_ready      (rsp_ready),
        .read_data      (read_data),
        .was_hit        (was_hit),
        .did_evict      (did_evict),
        .evicted_key    (evicted_key),
        .subscribe      (subscribe)
    );

    // clock
    always #5 clk = ~clk;

    // run limit
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("Regression FAIL");
            $finish;
        end
    end

    // lookup, lru update and insert for one request
    function automatic cache_rsp_t lookup_and_update(cache_req_t r);
        cache_rsp_t       res;
        int               slot;
        int               victim;
        int unsigned      eff_cap;
        int unsigned      old_age;
        logic [VAL_W-1:0] fill;
        res    = '0;
        slot   = -1;
        victim = -1;
        for (int i = 0; i < ENTRIES; i++)
            if (slot < 0 && shadow_live[i] && shadow_key[i] == r.key)
                slot = i;
        if (slot >= 0)
        begin
            // hit: promote to most recent, refresh if dirty
            res.hit = 1'b1;
            old_age = shadow_age[slot];
            for (int i = 0; i < ENTRIES; i++)
                if (shadow_live[i] && i != slot && shadow_age[i] < old_age)
                    shadow_age[i]++;
            shadow_age[slot] = 0;
            if (r.dirty)
                shadow_val[slot] = r.bdata;
            if (r.cmd == lkvc_pkg::CMD_WRITE)
                shadow_val[slot] = r.wdata;
            else
                res.data = shadow_val[slot];
        end
        else
        begin
            fill = (r.cmd == lkvc_pkg::CMD_WRITE) ? r.wdata : r.bdata;
            if (capacity_reg == 0)
                eff_cap = 1;
            else if (capacity_reg > ENTRIES)
                eff_cap = ENTRIES;
            else
                eff_cap = capacity_reg;
            // full: drop the least recent entry
            if (live_count >= eff_cap && live_count > 0)
            begin
                for (int i = 0; i < ENTRIES; i++)
                    if (shadow_live[i] && (victim < 0 || shadow_age[i] > shadow_age[victim]))
                        victim = i;
                if (victim >= 0)
                begin
                    res.evict           = 1'b1;
                    res.ekey            = shadow_key[victim];
                    shadow_live[victim] = 1'b0;
                    live_count--;
                    slot = victim;
                end
            end
            if (slot < 0)
                for (int i = 0; i < ENTRIES; i++)
                    if (slot < 0 && !shadow_live[i])
                        slot = i;
            // insert as most recent
            if (slot >= 0)
            begin
                for (int i = 0; i < ENTRIES; i++)
                    if (shadow_live[i])
                        shadow_age[i]++;
                shadow_live[slot] = 1'b1;
                shadow_key[slot]  = r.key;
                shadow_val[slot]  = fill;
                shadow_age[slot]  = 0;
                live_count++;
            end
            if (r.cmd == lkvc_pkg::CMD_READ)
            begin
                res.data = fill;
                res.sub  = 1'b1;
            end
        end
        return res;
    endfunction

    // request driver
    always @(posedge clk or negedge rst_n)
    begin : drive_req
        cache_req_t nxt;
        if (!rst_n)
        begin
            req_valid <= 1'b0;
        end
        else
        begin
            if (req_valid && req_ready)
                expected_rsps.push_back(lookup_and_update(
                    {cmd, req_key, write_data, backing_data, external_dirty}));
            if (!req_valid || req_ready)
            begin
                if (pending_reqs.size() != 0 && $urandom_range(0, 99) >= send_idle_pct)
                begin
                    nxt            = pending_reqs.pop_front();
                    cmd            <= nxt.cmd;
                    req_key        <= nxt.key;
                    write_data     <= nxt.wdata;
                    backing_data   <= nxt.bdata;
                    external_dirty <= nxt.dirty;
                    req_valid      <= 1'b1;
                end
                else
                begin
                    req_valid <= 1'b0;
                end
            end
        end
    end

    // response ready, with one long hold-off to back up the request side
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_ready <= 1'b0;
        end
        else
        begin
            if (rsp_valid && rsp_ready)
                rsp_seen <= rsp_seen + 1;
            if (!hold_done && rsp_seen >= HOLD_AT)
            begin
                hold_done <= 1'b1;
                hold_left <= HOLD_CYCLES;
                rsp_ready <= 1'b0;
            end
            else if (hold_left != 0)
            begin
                hold_left <= hold_left - 1;
                rsp_ready <= 1'b0;
            end
            else
            begin
                rsp_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
            end
        end
    end

    // response checker
    always @(posedge clk)
    begin : check_rsp
        cache_rsp_t want;
        if (rst_n && rsp_valid && rsp_ready)
        begin
            if (expected_rsps.size() == 0)
            begin
                $error("response beat with nothing expected");
                fail_count++;
            end
            else
            begin
                want = expected_rsps.pop_front();
                if (read_data !== want.data)
                begin
                    $error("read_data: expected %h, actual %h", want.data, read_data);
                    fail_count++;
                end
                if (was_hit !== want.hit)
                begin
                    $error("was_hit: expected %b, actual %b", want.hit, was_hit);
                    fail_count++;
                end
                if (did_evict !== want.evict)
                begin
                    $error("did_evict: expected %b, actual %b", want.evict, did_evict);
                    fail_count++;
                end
                if (evicted_key !== want.ekey)
                begin
                    $error("evicted_key: expected %h, actual %h", want.ekey, evicted_key);
                    fail_count++;
                end
                if (subscribe !== want.sub)
                begin
                    $error("subscribe: expected %b, actual %b", want.sub, subscribe);
                    fail_count++;
                end
            end
        end
    end

    task automatic queue_req(logic c, logic [KEY_W-1:0] k, logic [VAL_W-1:0] wd,
                             logic [VAL_W-1:0] bd, logic d);
        pending_reqs.push_back('{cmd: c, key: k, wdata: wd, bdata: bd, dirty: d});
    endtask

    // capacity register write, setup then access
    task automatic write_capacity(logic [DATA_W-1:0] value);
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= CAP_ADDR;
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel         <= 1'b0;
        penable      <= 1'b0;
        pwrite       <= 1'b0;
        capacity_reg = value[CAP_BITS-1:0];
    endtask

    // wait for the block to go quiet, then let any write-back finish
    task automatic wait_idle();
        @(negedge clk);
        while (pending_reqs.size() != 0 || req_valid || expected_rsps.size() != 0)
            @(negedge clk);
        repeat (SETTLE) @(posedge clk);
        @(negedge clk);
    endtask

    function automatic logic [VAL_W-1:0] rand_value();
        case ($urandom_range(0, 9))
            0:       return '0;
            1:       return '1;
            default: return {$urandom, $urandom};
        endcase
    endfunction

    function automatic logic [KEY_W-1:0] pick_key(int span);
        if ($urandom_range(0, 99) < 85)
            return key_pool[$urandom_range(0, span - 1)];
        return $urandom;
    endfunction

    // stimulus
    initial
    begin : stimulus
        int               span;
        int               caps[6];
        int               sends[6];
        int               recvs[6];
        logic [DATA_W-1:0] cfg;
        caps  = '{16, 1, 31, 0, 5, 16};
        sends = '{26, 26, 86, 86, 0, 0};
        recvs = '{86, 86, 26, 26, 0, 0};
        key_pool[0] = '0;
        key_pool[1] = '1;
        for (int i = 2; i < POOL_SIZE; i++)
            key_pool[i] = $urandom;

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);
        send_idle_pct = 26;
        recv_idle_pct = 86;

        // misses, hits, dirty refresh and dirty write at reset capacity
        queue_req(lkvc_pkg::CMD_READ,  32'h0000_0000, '0, '1, 1'b0);
        queue_req(lkvc_pkg::CMD_WRITE, 32'hFFFF_FFFF, '1, '0, 1'b0);
        queue_req(lkvc_pkg::CMD_READ,  32'h0000_0000, '1, '0, 1'b0);
        queue_req(lkvc_pkg::CMD_READ,  32'h0000_0000, '0, 64'hA5A5_5A5A_0F0F_F0F0, 1'b1);
        queue_req(lkvc_pkg::CMD_WRITE, 32'hFFFF_FFFF, '0, 64'h1234_5678_9ABC_DEF0, 1'b1);
        queue_req(lkvc_pkg::CMD_READ,  32'hFFFF_FFFF, '1, '1, 1'b0);
        queue_req(lkvc_pkg::CMD_READ,  32'h1234_5678, '1, 64'hDEAD_BEEF_CAFE_F00D, 1'b1);
        queue_req(lkvc_pkg::CMD_WRITE, 32'h0000_0001, '0, '1, 1'b1);
        wait_idle();

        // capacity lowered below occupancy
        write_capacity(32'd2);
        queue_req(lkvc_pkg::CMD_WRITE, 32'h0000_000A, 64'h1111, '0, 1'b0);
        queue_req(lkvc_pkg::CMD_READ,  32'h0000_000B, '0, 64'h2222, 1'b0);
        queue_req(lkvc_pkg::CMD_READ,  32'h0000_000A, '0, '0, 1'b0);
        queue_req(lkvc_pkg::CMD_WRITE, 32'h0000_000C, 64'h3333, '1, 1'b1);
        queue_req(lkvc_pkg::CMD_READ,  32'h0000_000B, '0, 64'h4444, 1'b0);
        wait_idle();

        // zero capacity acts as one
        write_capacity(32'hFFFF_FFE0);
        queue_req(lkvc_pkg::CMD_READ,  32'h0000_000D, '0, 64'h5555, 1'b0);
        queue_req(lkvc_pkg::CMD_READ,  32'h0000_000D, '0, '1, 1'b0);
        queue_req(lkvc_pkg::CMD_WRITE, 32'h0000_000E, '1, '0, 1'b0);
        queue_req(lkvc_pkg::CMD_READ,  32'h0000_000D, '0, 64'h6666, 1'b1);
        wait_idle();

        // capacity above the store size acts as full size
        write_capacity(32'h8000_001F);
        queue_req(lkvc_pkg::CMD_READ,  32'h0000_000D, '0, '0, 1'b0);
        queue_req(lkvc_pkg::CMD_WRITE, 32'h0000_0010, 64'h7777, '0, 1'b0);
        queue_req(lkvc_pkg::CMD_READ,  32'h0000_0011, '0, 64'h8888, 1'b0);
        queue_req(lkvc_pkg::CMD_READ,  32'h0000_0010, '0, '0, 1'b1);
        wait_idle();

        // random phases over several capacities and idle mixes
        for (int p = 0; p < 6; p++)
        begin
            send_idle_pct = sends[p];
            recv_idle_pct = recvs[p];
            cfg = $urandom;
            cfg[CAP_BITS-1:0] = CAP_BITS'(caps[p]);
            write_capacity(cfg);
            if (caps[p] == 0)
                span = 5;
            else if (caps[p] > ENTRIES)
                span = ENTRIES + 4;
            else
                span = caps[p] + 4;
            for (int n = 0; n < PHASE_ITEMS; n++)
                queue_req(logic'($urandom_range(0, 1)), pick_key(span), rand_value(),
                          rand_value(), ($urandom_range(0, 99) < 25));
            wait_idle();
        end

        if (fail_count == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
